### src/nwfs_pkg.sv
// nwfs_pkg: field widths, saturation limits and the result word type shared by
// the no-wait flow shop evaluator. No dependencies.
package nwfs_pkg;

	localparam int PROC_W = 16;  // processing time per machine
	localparam int CFG_W  = 5;   // machine count register
	localparam int TIME_W = 32;  // time values, saturating
	localparam int COST_W = 40;  // total completion time, saturating

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef logic [TIME_W-1:0] tval_t;

	typedef struct packed {
		logic [TIME_W-1:0] job_completion;
		logic [COST_W-1:0] total_cost;
		logic              overflow;
	} result_t;

endpackage

### src/no_wait_flow_shop_evaluator.sv
// no_wait_flow_shop_evaluator: top level of the no-wait flow shop evaluator.
// Depends on nwfs_pkg, nwfs_front, nwfs_queue and nwfs_back.
//
// Takes processing times one word per machine, job after job, and gives one
// result word per job on its last machine: the job's completion time, the
// running total completion time of the sequence and a sticky overflow flag
// (times saturate at 2^32-1, the cost at 2^40-1). Raise new_sequence on the
// first word of a sequence; it drops any partial job. machine_count (1 to
// MAX_MACHINES, 0 acts as 1, larger acts as MAX_MACHINES) is written through
// the cfg channel, which is always ready; the user must write it only while
// the block is idle, which the block does not enforce. Raising it after a
// job of the current sequence has finished reads store entries that were
// never written. Rate is one word per clock, sustained, whatever the mix of
// jobs, unless the result side stalls: the delay and prefix update for a word
// is done in a single evaluation stage, and the previous job's per-machine
// prefixes sit in a MAX_MACHINES-entry store read one word ahead with a
// same-edge bypass, so no bubbles are needed at job boundaries. Words pass
// the input queue, store read, evaluation and cost add in turn. Four-entry
// queues at the input and result sides let either side stall without
// stopping the other; full only rises when the input queue backs up behind
// a stalled result side. No clearing pass is needed after reset.
module no_wait_flow_shop_evaluator
	import nwfs_pkg::*;
#(
	parameter int MAX_MACHINES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    machine_count,
	// input words
	input  logic                push,
	output logic                full,
	input  logic [PROC_W-1:0]   processing_time,
	input  logic                new_sequence,
	// result words
	output logic                empty,
	input  logic                pop,
	output logic [TIME_W-1:0]   job_completion,
	output logic [COST_W-1:0]   total_cost,
	output logic                overflow
);

	localparam int IdxW   = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
	localparam int ItemW  = PROC_W + 2 + IdxW;
	localparam int QDepth = 4;

	logic             fq_push, fq_full, fq_pop, fq_empty;
	logic [ItemW-1:0] fq_wdata, fq_rdata;
	logic             rq_push, rq_full;
	result_t          rq_wdata, rq_rdata;

	// classification: machine index and last-machine mark per word
	nwfs_front #(
		.MAX_MACHINES (MAX_MACHINES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_count (machine_count),
		.in_push   (push),
		.in_time   (processing_time),
		.in_new    (new_sequence),
		.q_full    (fq_full),
		.q_push    (fq_push),
		.q_data    (fq_wdata)
	);

	assign full = fq_full;

	// decouples classification from evaluation
	nwfs_queue #(
		.Width (ItemW),
		.Depth (QDepth)
	) u_in_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_wdata),
		.full   (fq_full),
		.pop    (fq_pop),
		.rdata  (fq_rdata),
		.empty  (fq_empty)
	);

	// store read, delay evaluation, cost add
	nwfs_back #(
		.MAX_MACHINES (MAX_MACHINES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (fq_empty),
		.q_pop   (fq_pop),
		.q_data  (fq_rdata),
		.r_full  (rq_full),
		.r_push  (rq_push),
		.r_data  (rq_wdata)
	);

	// result words wait here for the consumer
	nwfs_queue #(
		.Width ($bits(result_t)),
		.Depth (QDepth)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign job_completion = rq_rdata.job_completion;
	assign total_cost     = rq_rdata.total_cost;
	assign overflow       = rq_rdata.overflow;

endmodule

### src/nwfs_queue.sv
// nwfs_queue: small synchronous FIFO with full/empty flags.
// Uses no package; width and depth come from parameters.
module nwfs_queue #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	logic [Width-1:0] slot_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (PtrW+1)'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (PtrW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (PtrW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wdata;
	end

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue flags full and empty together");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PtrW+1)'(Depth))
		else $error("queue count beyond depth");

endmodule

### src/nwfs_front.sv
// nwfs_front: machine count register and input classification (machine index,
// last-machine mark). Depends on nwfs_pkg.
module nwfs_front
	import nwfs_pkg::*;
#(
	parameter int MAX_MACHINES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_count,
	input  logic                 in_push,
	input  logic [PROC_W-1:0]    in_time,
	input  logic                 in_new,
	input  logic                 q_full,
	output logic                 q_push,
	output logic [PROC_W+1+((MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1):0] q_data
);

	localparam int IdxW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
	localparam int CntW = $clog2(MAX_MACHINES + 1);

	logic [CFG_W-1:0] count_q;
	logic [IdxW-1:0]  idx_q;
	logic [IdxW-1:0]  idx_now;
	logic [CntW-1:0]  m_eff, idx_inc;
	logic             is_last;

	assign cfg_ready = 1'b1;
	assign q_push    = in_push & ~q_full;

	// out-of-range counts: zero acts as one, above the store depth as the depth
	always_comb begin
		if (count_q == '0)
			m_eff = CntW'(1);
		else if (32'(count_q) >= 32'(MAX_MACHINES))
			m_eff = CntW'(MAX_MACHINES);
		else
			m_eff = CntW'(count_q);
	end

	assign idx_now = in_new ? '0 : idx_q;
	assign idx_inc = CntW'(idx_now) + CntW'(1);
	assign is_last = (idx_inc >= m_eff);
	assign q_data  = {in_time, in_new, is_last, idx_now};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CFG_W'(1);
			idx_q   <= '0;
		end else begin
			if (cfg_valid)
				count_q <= cfg_count;
			if (q_push)
				idx_q <= is_last ? '0 : IdxW'(idx_inc);
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) < 32'(MAX_MACHINES))
		else $error("machine index outside the store");

endmodule

### src/nwfs_back.sv
// nwfs_back: prefix store, start-delay evaluation and cost accumulation.
// Three stages: store read, job evaluation, cost add. Depends on nwfs_pkg.
module nwfs_back
	import nwfs_pkg::*;
#(
	parameter int MAX_MACHINES = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	output logic    q_pop,
	input  logic [PROC_W+1+((MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1):0] q_data,
	input  logic    r_full,
	output logic    r_push,
	output result_t r_data
);

	localparam int IdxW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
	localparam int CntW = $clog2(MAX_MACHINES + 1);
	localparam int TW1  = TIME_W + 1;
	localparam int TW2  = TIME_W + 2;
	localparam int CW1  = COST_W + 1;

	// incoming word
	logic [PROC_W-1:0] q_time;
	logic              q_new, q_last;
	logic [IdxW-1:0]   q_idx;
	logic [CntW-1:0]   q_inc;
	logic [IdxW-1:0]   raddr;

	// stage 1: store read
	logic              valid_s1, new_s1, last_s1, byp_s1;
	logic [PROC_W-1:0] time_s1;
	logic [IdxW-1:0]   idx_s1, raddr_s1;
	tval_t             mem_rd_s1, bypd_s1, rd1;

	// stage 2: job evaluation
	logic              valid_s2, new_s2, last_s2;
	logic [PROC_W-1:0] time_s2;
	logic [IdxW-1:0]   idx_s2;
	tval_t             rd_s2;

	// stage 3: cost add
	logic              valid_s3, clr_s3, ovf_s3;
	tval_t             compl_s3;

	tval_t store_mem [MAX_MACHINES];

	// per-sequence state
	tval_t              rp_q, cd_q, pd_q, rp0_q, store0_q;
	logic               first_q, ovf_q, clr_q, rp0_ovf_q, covf_q;
	logic [COST_W-1:0]  cost_q;

	logic en1, en2, en3, adv1, adv2, adv3, ld1, we;

	// evaluation terms
	logic        first_w, start_w, upd_w, c_ovf, ovf_w, clr_w;
	tval_t       pd_w, rp_in, cd_w, base_w, compl_w, nxt_w, diff_w, rp0_w;
	logic [TW1-1:0] sum_b, sum_t, sum_r0;
	logic [TW2-1:0] sum_c;

	logic [COST_W-1:0] cost_in, cost_new;
	logic [CW1-1:0]    sum_cost;
	logic              covf_in;

	assign {q_time, q_new, q_last, q_idx} = q_data;
	assign q_inc = CntW'(q_idx) + CntW'(1);
	// entry 0 lives in store0_q; last words need no look-ahead
	assign raddr = q_last ? '0 : IdxW'(q_inc);

	// flow control: a word that is not a job's last never waits on stage 3
	assign en3   = ~valid_s3 | ~r_full;
	assign adv3  = valid_s3 & ~r_full;
	assign adv2  = valid_s2 & (~last_s2 | en3);
	assign en2   = ~valid_s2 | adv2;
	assign en1   = ~valid_s1 | en2;
	assign adv1  = valid_s1 & en2;
	assign ld1   = ~q_empty & en1;
	assign q_pop = ld1;
	assign we    = adv2;

	assign rd1 = byp_s1 ? bypd_s1 : mem_rd_s1;

	// ---- job evaluation ----
	assign first_w = new_s2 | first_q;
	assign pd_w    = new_s2 ? '0 : pd_q;
	assign start_w = (idx_s2 == '0);
	assign rp_in   = start_w ? (first_w ? '0 : rp0_q) : rp_q;
	assign cd_w    = start_w ? '0 : cd_q;

	assign sum_b  = TW1'(rp_in) + TW1'(time_s2);
	assign base_w = sum_b[TIME_W] ? TIME_MAX : sum_b[TIME_W-1:0];

	// saturating adds of non-negative values chain freely: one three-input sum
	assign sum_c   = TW2'(rp_in) + TW2'(time_s2) + TW2'(cd_w);
	assign c_ovf   = |sum_c[TW2-1:TIME_W];
	assign compl_w = c_ovf ? TIME_MAX : sum_c[TIME_W-1:0];

	// previous job's completion on the next machine
	assign sum_t = TW1'(rd_s2) + TW1'(pd_w);
	assign nxt_w = first_w ? '0 : (sum_t[TIME_W] ? TIME_MAX : sum_t[TIME_W-1:0]);

	// nxt - base > delay  <=>  nxt > prefix + time + delay (unsaturated)
	assign upd_w  = TW2'(nxt_w) > sum_c;
	assign diff_w = nxt_w - sum_b[TIME_W-1:0];

	// machine-0 start of the following job, ready at this job's end
	assign sum_r0 = TW1'(store0_q) + TW1'(cd_w);
	assign rp0_w  = start_w ? base_w
		: (sum_r0[TIME_W] ? TIME_MAX : sum_r0[TIME_W-1:0]);

	assign ovf_w = (~new_s2 & ovf_q) | (start_w & ~first_w & rp0_ovf_q) | sum_b[TIME_W]
		| (last_s2 ? c_ovf : (~first_w & sum_t[TIME_W]));
	assign clr_w = clr_q | new_s2;

	// ---- cost add ----
	assign cost_in  = clr_s3 ? '0 : cost_q;
	assign covf_in  = ~clr_s3 & covf_q;
	assign sum_cost = CW1'(cost_in) + CW1'(compl_s3);
	assign cost_new = sum_cost[COST_W] ? COST_MAX : sum_cost[COST_W-1:0];

	assign r_push = adv3;
	assign r_data = '{job_completion: compl_s3,
	                  total_cost:     cost_new,
	                  overflow:       ovf_s3 | covf_in | sum_cost[COST_W]};

	// prefix store, read data registered; same-edge write is bypassed
	always_ff @(posedge clk) begin
		if (we)
			store_mem[idx_s2] <= base_w;
		if (ld1)
			mem_rd_s1 <= store_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1)
				valid_s1 <= ld1;
			if (en2)
				valid_s2 <= valid_s1;
			if (en3)
				valid_s3 <= adv2 & last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			time_s1  <= q_time;
			new_s1   <= q_new;
			last_s1  <= q_last;
			idx_s1   <= q_idx;
			raddr_s1 <= raddr;
			byp_s1   <= we && (idx_s2 == raddr);
			bypd_s1  <= base_w;
		end
		if (adv1) begin
			time_s2 <= time_s1;
			new_s2  <= new_s1;
			last_s2 <= last_s1;
			idx_s2  <= idx_s1;
			rd_s2   <= (we && (idx_s2 == raddr_s1)) ? base_w : rd1;
		end
		if (adv2 && last_s2) begin
			compl_s3 <= compl_w;
			clr_s3   <= clr_w;
			ovf_s3   <= ovf_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			cd_q      <= '0;
			pd_q      <= '0;
			rp0_q     <= '0;
			store0_q  <= '0;
			first_q   <= 1'b1;
			ovf_q     <= 1'b0;
			clr_q     <= 1'b0;
			rp0_ovf_q <= 1'b0;
			cost_q    <= '0;
			covf_q    <= 1'b0;
		end else begin
			if (adv2) begin
				rp_q  <= base_w;
				ovf_q <= ovf_w;
				if (start_w)
					store0_q <= base_w;
				if (last_s2) begin
					cd_q      <= '0;
					pd_q      <= cd_w;
					first_q   <= 1'b0;
					clr_q     <= 1'b0;
					rp0_q     <= rp0_w;
					rp0_ovf_q <= ~start_w & sum_r0[TIME_W];
				end else begin
					cd_q    <= upd_w ? diff_w : cd_w;
					pd_q    <= pd_w;
					first_q <= first_w;
					clr_q   <= clr_w;
				end
			end
			if (adv3) begin
				cost_q <= cost_new;
				covf_q <= covf_in | sum_cost[COST_W];
			end
		end
	end

	a_job_end_state: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && last_s2) |=> (cd_q == '0) && !first_q)
		else $error("delay or first-job mark not settled at job end");

	a_inner_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !last_s2) |-> adv2)
		else $error("inner machine word held in evaluation stage");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && r_full) |=> valid_s3 && $stable(compl_s3))
		else $error("pending result lost while result queue full");

endmodule

### dv/tb_top.sv
// tb_top: self-checking bench for no_wait_flow_shop_evaluator. It drives processing-time
// words, predicts each job's completion, running cost and overflow flag, and checks them.
// Depends on nwfs_pkg and the evaluator RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nwfs_pkg::*;

	localparam int MAX_M       = 16;
	localparam int SETTLE      = 10;    // edges for in-flight words that give no result
	localparam int HOLD_CYCLES = 80;    // long result-side hold-off
	localparam int MAXT_WORDS  = 48;    // back-to-back maximum times on one machine
	localparam int PHASE_WORDS = 500;

	// Shadow of the evaluator: machine count, per-machine prefixes of the last
	// finished job, delays, running cost, and the queue of job results still owed.
	class flow_shop_scoreboard;
		logic [CFG_W-1:0]  count_reg;
		tval_t             prefix_mem[MAX_M];
		tval_t             prev_delay;
		tval_t             cur_delay;
		tval_t             run_prefix;
		int unsigned       mach_idx;
		bit                first_job;
		logic [COST_W-1:0] cost;
		bit                ovf;
		result_t           pending[$];
		int unsigned       checked;
		int unsigned       fail_count;
		int unsigned       saturated;

		function void clear();
			count_reg  = CFG_W'(1);
			foreach (prefix_mem[k]) prefix_mem[k] = '0;
			prev_delay = '0;
			cur_delay  = '0;
			run_prefix = '0;
			mach_idx   = 0;
			first_job  = 1'b1;
			cost       = '0;
			ovf        = 1'b0;
		endfunction

		function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
			logic [63:0] s;
			s = a + b;
			if (s > lim) begin
				ovf = 1'b1;
				return lim;
			end
			return s;
		endfunction

		// completion of the previous job on machine k, zero with no previous job
		function logic [63:0] prev_finish(int unsigned k);
			if (first_job || k >= MAX_M)
				return 64'(0);
			return sat_sum(64'(prefix_mem[k]), 64'(prev_delay), 64'(TIME_MAX));
		endfunction

		function void note_word(logic [PROC_W-1:0] p, bit ns);
			int unsigned m, i;
			logic [63:0] base, nxt, fin;
			result_t r;
			m = 32'(count_reg);
			if (m < 1) m = 1;
			if (m > MAX_M) m = MAX_M;
			if (ns) begin
				first_job  = 1'b1;
				mach_idx   = 0;
				cost       = '0;
				ovf        = 1'b0;
				prev_delay = '0;
			end
			i = (mach_idx >= MAX_M) ? 0 : mach_idx;
			if (i == 0) begin
				cur_delay  = '0;
				run_prefix = TIME_W'(prev_finish(0));
			end
			base = sat_sum(64'(run_prefix), 64'(p), 64'(TIME_MAX));
			run_prefix = base[TIME_W-1:0];
			if (i + 1 < m) begin
				// not the last machine: widen the delay if the previous job is in the way
				nxt = prev_finish(i + 1);
				if (nxt > base && nxt - base > 64'(cur_delay))
					cur_delay = TIME_W'(nxt - base);
				prefix_mem[i] = base[TIME_W-1:0];
				mach_idx = i + 1;
				return;
			end
			prefix_mem[i] = base[TIME_W-1:0];
			fin  = sat_sum(base, 64'(cur_delay), 64'(TIME_MAX));
			cost = COST_W'(sat_sum(64'(cost), fin, 64'(COST_MAX)));
			prev_delay = cur_delay;
			cur_delay  = '0;
			mach_idx   = 0;
			first_job  = 1'b0;
			r.job_completion = fin[TIME_W-1:0];
			r.total_cost     = cost;
			r.overflow       = ovf;
			pending = {pending, r};
		endfunction

		function void flag(string field, logic [63:0] want, logic [63:0] got);
			fail_count++;
			if (fail_count <= 10)
				$display("result %0d: %s expected %0d, got %0d", checked, field, want, got);
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (got.overflow) saturated++;
			if (pending.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result %0d arrived with none owed: completion %0d cost %0d",
						checked, got.job_completion, got.total_cost);
				return;
			end
			want = pending.pop_front();
			if (got.job_completion !== want.job_completion)
				flag("job_completion", 64'(want.job_completion), 64'(got.job_completion));
			if (got.total_cost !== want.total_cost)
				flag("total_cost", 64'(want.total_cost), 64'(got.total_cost));
			if (got.overflow !== want.overflow)
				flag("overflow", 64'(want.overflow), 64'(got.overflow));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    machine_count;
	logic                push;
	logic                full;
	logic [PROC_W-1:0]   processing_time;
	logic                new_sequence;
	logic                empty;
	logic                pop;
	logic [TIME_W-1:0]   job_completion;
	logic [COST_W-1:0]   total_cost;
	logic                overflow;

	flow_shop_scoreboard sb;
	int unsigned         send_idle;     // percent of cycles the sender sits out
	int unsigned         recv_idle;     // percent of cycles the receiver sits out
	bit                  hold_request;  // asks the receiver for one long hold-off
	int unsigned         words_sent;
	int unsigned         input_stalls;
	int unsigned         count_writes;

	no_wait_flow_shop_evaluator #(.MAX_MACHINES(MAX_M)) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.machine_count  (machine_count),
		.push           (push),
		.full           (full),
		.processing_time(processing_time),
		.new_sequence   (new_sequence),
		.empty          (empty),
		.pop            (pop),
		.job_completion (job_completion),
		.total_cost     (total_cost),
		.overflow       (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("no_wait_flow_shop_evaluator: mismatch");
		$finish;
	end

	// Result side: pop at random per recv_idle, one long hold-off on request,
	// and check every word taken against the oldest owed result.
	initial begin
		bit          taking;
		int unsigned held;
		result_t     got;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				pop <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_request = 1'b0;
			end
			taking = !(recv_idle != 0 && $urandom_range(0, 99) < recv_idle);
			pop <= taking;
			@(posedge clk);
			if (taking && !empty) begin
				got.job_completion = job_completion;
				got.total_cost     = total_cost;
				got.overflow       = overflow;
				sb.check_result(got);
			end
		end
	end

	// One input word; push stays high across back-to-back words, so it is
	// only lowered when an idle cycle is actually taken.
	task automatic send_word(input logic [PROC_W-1:0] p, input bit ns);
		@(negedge clk);
		while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push            <= 1'b1;
		processing_time <= p;
		new_sequence    <= ns;
		forever begin
			@(posedge clk);
			if (!full) break;
			input_stalls++;
		end
		sb.note_word(p, ns);
		words_sent++;
	endtask

	// Stop sending, wait for every owed result, then let any trailing
	// no-result words clear the pipeline.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid     <= 1'b1;
		machine_count <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.count_reg = v;
		count_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mix of extremes and tiny times (to make delays likely) with full-range values.
	function automatic logic [PROC_W-1:0] pick_time();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return PROC_W'($urandom_range(0, 15));
			default: return PROC_W'($urandom);
		endcase
	endfunction

	// Mostly short jobs, now and then long ones and out-of-range counts.
	function automatic logic [CFG_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_W'($urandom_range(17, 31));
			2, 3, 4: return CFG_W'($urandom_range(1, 4));
			5, 6, 7: return CFG_W'($urandom_range(5, 8));
			default: return CFG_W'($urandom_range(9, 16));
		endcase
	endfunction

	// Random sequences of whole jobs; one job in ten is cut short and its
	// sequence abandoned, so the next new_sequence word drops the partial job.
	// A count change is always followed by a new sequence, so the store is
	// never read beyond what the previous job wrote.
	task automatic run_random(input int unsigned target);
		int unsigned goal, jobs, len, m;
		bit          ns, cut;
		goal = words_sent + target;
		while (words_sent < goal) begin
			if ($urandom_range(0, 3) == 0) begin
				drain();
				write_count(pick_count());
			end
			m = 32'(sb.count_reg);
			if (m < 1) m = 1;
			if (m > MAX_M) m = MAX_M;
			jobs = $urandom_range(1, 10);
			ns   = 1'b1;
			cut  = 1'b0;
			for (int j = 0; j < jobs && !cut; j++) begin
				len = m;
				if ($urandom_range(0, 9) == 0) begin
					len = $urandom_range(1, m);
					cut = 1'b1;
				end
				for (int w = 0; w < len; w++) begin
					send_word(pick_time(), ns);
					ns = 1'b0;
				end
			end
		end
	endtask

	initial begin
		sb = new;
		sb.clear();
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		machine_count   = '0;
		push            = 1'b0;
		processing_time = '0;
		new_sequence    = 1'b0;
		hold_request    = 1'b0;
		send_idle       = 36;
		recv_idle       = 79;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// three machines: extreme times, then an all-zero job that must be
		// pushed back by the delay of the all-max job before it
		write_count(CFG_W'(3));
		send_word('0, 1'b1);
		send_word('1, 1'b0);
		send_word('0, 1'b0);
		repeat (3) send_word('1, 1'b0);
		repeat (3) send_word('0, 1'b0);
		// new sequence in mid-job drops the partial job
		send_word(16'd100, 1'b1);
		send_word(16'd7, 1'b0);
		send_word(16'd5, 1'b1);
		send_word(16'd1, 1'b0);
		send_word(16'd2, 1'b0);
		// count raised in mid-job while still on the first job of a sequence
		drain();
		write_count(CFG_W'(4));
		send_word(16'd10, 1'b1);
		send_word(16'd20, 1'b0);
		drain();
		write_count(CFG_W'(6));
		send_word(16'd30, 1'b0);
		send_word('1, 1'b0);
		send_word('0, 1'b0);
		send_word(16'd5, 1'b0);
		// count lowered in mid-job (zero acts as one): the fourth word ends the job
		repeat (3) send_word(pick_time(), 1'b0);
		drain();
		write_count(CFG_W'(0));
		repeat (3) send_word(pick_time(), 1'b0);

		// --- random, sender 36 % idle, receiver 79 % ---
		run_random(PHASE_WORDS);

		// --- random, roles swapped; top of the count range first ---
		drain();
		send_idle = 79;
		recv_idle = 36;
		write_count(CFG_W'(31));
		run_random(PHASE_WORDS);

		// --- no idling: long receiver hold-off while words keep coming so
		// the queues fill and full rises, then a pause until all is back ---
		drain();
		send_idle = 0;
		recv_idle = 0;
		write_count(CFG_W'(1));
		hold_request = 1'b1;
		for (int n = 0; n < 40; n++)
			send_word(pick_time(), n == 0);
		drain();
		write_count(CFG_W'(16));
		run_random(PHASE_WORDS);

		// --- one machine, maximum times back to back, then a fresh sequence ---
		drain();
		write_count(CFG_W'(1));
		for (int n = 0; n < MAXT_WORDS; n++)
			send_word('1, n == 0);
		for (int n = 0; n < 6; n++)
			send_word(pick_time(), n == 0);

		drain();
		$display("covered %0d input words, %0d job results (%0d with overflow set)",
			words_sent, sb.checked, sb.saturated);
		$display("%0d machine count writes, %0d cycles with the input held off by full",
			count_writes, input_stalls);
		if (sb.fail_count == 0 && sb.pending.size() == 0) begin
			$display("no_wait_flow_shop_evaluator: match");
		end else begin
			$display("no_wait_flow_shop_evaluator: mismatch");
		end
		$finish;
	end

endmodule
